[hw/rtl/mcit_pkg.sv]
`timescale 1ns / 1ps

package mcit_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_NODES_DEF  = 8;
    localparam int INDEX_BITS_DEF = 32;

    // Depth of the command queue between the front and the back part (power of two).
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_SELF_ID    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [3:0] NODE_COUNT_RST = 4'd3;
    localparam logic [2:0] SELF_ID_RST    = 3'd0;

    // Item kinds carried in the mode field.
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [2:0]  node;
        logic [31:0] log_index;
    } t_in_word;

    typedef struct packed {
        logic [31:0] commit_before;
        logic [31:0] commit_after;
        logic        advanced;
    } t_out_word;

    // What the front part decided about one item.
    typedef struct packed {
        logic is_start;  // open a new term
        logic store;     // write the match table entry
        logic set_len;   // the reporting node is the leader itself
    } t_cmd_flags;

endpackage

[hw/rtl/mcit_front.sv]
`timescale 1ns / 1ps

module mcit_front #(
    parameter int MAX_NODES  = mcit_pkg::MAX_NODES_DEF,
    parameter int INDEX_BITS = mcit_pkg::INDEX_BITS_DEF,
    parameter int NODE_BITS  = 1
) (
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mcit_pkg::t_in_word     i_in_data,
    input  logic [2:0]             i_self_id,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output mcit_pkg::t_cmd_flags   o_flags,
    output logic [NODE_BITS-1:0]   o_node,
    output logic [INDEX_BITS-1:0]  o_index
);
    import mcit_pkg::*;

    logic [63:0] w_index64;
    logic [7:0]  w_node8;
    logic        w_in_table;
    logic        w_start;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    assign w_index64  = {32'd0, i_in_data.log_index};
    assign w_node8    = {5'd0, i_in_data.node};
    assign w_in_table = ({29'd0, i_in_data.node} < 32'(MAX_NODES));
    assign w_start    = (i_in_data.mode == MODE_START);

    assign o_flags.is_start = w_start;
    assign o_flags.store    = !w_start && w_in_table;
    assign o_flags.set_len  = !w_start && (i_in_data.node == i_self_id);
    assign o_node           = w_node8[NODE_BITS-1:0];
    assign o_index          = w_index64[INDEX_BITS-1:0];

endmodule

[hw/rtl/mcit_queue.sv]
`timescale 1ns / 1ps

module mcit_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    import mcit_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_do_push;
    logic                w_do_pop;

    assign o_full    = (r_cnt == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rdata   = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = w_do_push ? r_wr + PTR_BITS'(1) : r_wr;
        n_rd  = w_do_pop ? r_rd + PTR_BITS'(1) : r_rd;
        n_cnt = r_cnt + CNT_BITS'(w_do_push) - CNT_BITS'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

[hw/rtl/mcit_back.sv]
`timescale 1ns / 1ps

module mcit_back #(
    parameter int MAX_NODES  = mcit_pkg::MAX_NODES_DEF,
    parameter int INDEX_BITS = mcit_pkg::INDEX_BITS_DEF,
    parameter int NODE_BITS  = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_pop,
    input  mcit_pkg::t_cmd_flags   i_cmd_flags,
    input  logic [NODE_BITS-1:0]   i_cmd_node,
    input  logic [INDEX_BITS-1:0]  i_cmd_index,
    input  logic [3:0]             i_node_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mcit_pkg::t_out_word    o_out_data
);
    import mcit_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [INDEX_BITS-1:0] r_table [MAX_NODES];
    logic [INDEX_BITS-1:0] r_commit;
    logic [INDEX_BITS-1:0] r_term;
    logic [INDEX_BITS-1:0] r_len;
    logic [CNT_BITS-1:0]   r_i;
    logic                  r_found;
    logic [INDEX_BITS-1:0] r_best;
    logic [INDEX_BITS-1:0] r_before;
    logic                  r_out_valid;
    t_out_word             r_out_data;

    logic [CNT_BITS-1:0]   w_active;
    logic [CNT_BITS-1:0]   w_maj;
    logic [INDEX_BITS-1:0] w_cand;
    logic [MAX_NODES-1:0]  w_ge;
    logic [CNT_BITS-1:0]   w_reach;
    logic                  w_take;
    logic                  w_last;
    logic [INDEX_BITS-1:0] w_capped;
    logic [INDEX_BITS-1:0] w_commit_new;
    logic [INDEX_BITS-1:0] w_term_new;
    logic                  w_slot_free;
    logic                  w_load_out;
    logic [63:0]           w_before64;
    logic [63:0]           w_after64;

    assign w_active = (32'(i_node_count) > 32'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                           : CNT_BITS'(i_node_count);
    assign w_maj    = (w_active >> 1) + CNT_BITS'(1);

    // One candidate per scan cycle, compared against every active entry at once.
    assign w_cand = r_table[r_i[NODE_BITS-1:0]];
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            w_ge[j] = (CNT_BITS'(j) < w_active) && (r_table[j] >= w_cand);
        end
    end
    assign w_reach = CNT_BITS'($countones(w_ge));
    assign w_take  = (w_reach >= w_maj) && (!r_found || (w_cand > r_best));
    assign w_last  = ((r_i + CNT_BITS'(1)) == w_active);

    assign w_capped     = (r_best > r_len) ? r_len : r_best;
    assign w_commit_new = (r_found && (w_capped >= r_term) && (w_capped > r_commit))
                          ? w_capped : r_commit;
    assign w_term_new   = (i_cmd_index == '1) ? i_cmd_index
                                              : i_cmd_index + INDEX_BITS'(1);

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign w_load_out  = (r_state == S_DONE) && w_slot_free;

    assign w_before64 = 64'(r_before);
    assign w_after64  = 64'(w_commit_new);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (w_active == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_commit    <= '0;
            r_term      <= '0;
            r_len       <= '0;
            r_i         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_NODES; k++) begin
                r_table[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_i     <= '0;
                r_found <= 1'b0;
                if (i_cmd_flags.is_start) begin
                    r_len  <= i_cmd_index;
                    r_term <= w_term_new;
                    for (int k = 0; k < MAX_NODES; k++) begin
                        r_table[k] <= '0;
                    end
                end else begin
                    if (i_cmd_flags.store) begin
                        r_table[i_cmd_node] <= i_cmd_index;
                    end
                    if (i_cmd_flags.set_len) begin
                        r_len <= i_cmd_index;
                    end
                end
            end
            if (r_state == S_SCAN) begin
                r_i <= r_i + CNT_BITS'(1);
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
            if (w_load_out) begin
                r_commit    <= w_commit_new;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_before <= r_commit;
        end
        if ((r_state == S_SCAN) && w_take) begin
            r_best <= w_cand;
        end
        if (w_load_out) begin
            r_out_data.commit_before <= w_before64[31:0];
            r_out_data.commit_after  <= w_after64[31:0];
            r_out_data.advanced      <= (w_commit_new > r_commit);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/majority_commit_index_tracker.sv]
`timescale 1ns / 1ps

// Leader-side commit index tracker. Each input word is either a term start
// (mode 0, carrying the saved log length) or a match index report from one
// node (mode 1); every word yields exactly one result word holding the commit
// index before and after it and a flag that says whether it advanced. The
// front part takes one word per cycle into a two-entry command queue while
// the queue has room, so a short burst is absorbed at once. The back part
// handles one word at a time, with n being node_count capped at MAX_NODES:
// it applies the word to the match table, walks the table one candidate per
// cycle for n candidates (each candidate is compared against all active
// entries in parallel to count how many nodes have reached it), then commits
// and loads the output register, and only then takes the next word. The
// output register lets the back part start the next word while a finished
// result still waits under stall. Configuration (node_count at byte address
// 0, self_id at byte address 4) must be written through the APB port only
// while no word is in flight; the block itself does not enforce this.

module majority_commit_index_tracker #(
    parameter int MAX_NODES  = mcit_pkg::MAX_NODES_DEF,
    parameter int INDEX_BITS = mcit_pkg::INDEX_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mcit_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mcit_pkg::t_out_word  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mcit_pkg::*;

    localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FLAG_BITS = $bits(t_cmd_flags);
    localparam int QW        = FLAG_BITS + NODE_BITS + INDEX_BITS;

    // Configuration registers.
    logic [3:0] r_node_count;
    logic [2:0] r_self_id;
    logic       w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_self_id    <= SELF_ID_RST;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_NODE_COUNT: r_node_count <= pwdata[3:0];
                REG_SELF_ID:    r_self_id    <= pwdata[2:0];
                default:        r_self_id    <= r_self_id;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NODE_COUNT: prdata = {28'd0, r_node_count};
            REG_SELF_ID:    prdata = {29'd0, r_self_id};
            default:        prdata = 32'd0;
        endcase
    end

    // Front part: accept and classify words.
    logic                  w_push;
    t_cmd_flags            w_push_flags;
    logic [NODE_BITS-1:0]  w_push_node;
    logic [INDEX_BITS-1:0] w_push_index;
    logic                  w_queue_full;

    mcit_front #(
        .MAX_NODES  (MAX_NODES),
        .INDEX_BITS (INDEX_BITS),
        .NODE_BITS  (NODE_BITS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_self_id    (r_self_id),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_flags      (w_push_flags),
        .o_node       (w_push_node),
        .o_index      (w_push_index)
    );

    // Command queue that decouples the two parts.
    logic [QW-1:0]         w_q_wdata;
    logic [QW-1:0]         w_q_rdata;
    logic                  w_q_valid;
    logic                  w_q_pop;
    t_cmd_flags            w_cmd_flags;
    logic [NODE_BITS-1:0]  w_cmd_node;
    logic [INDEX_BITS-1:0] w_cmd_index;

    assign w_q_wdata = {w_push_flags, w_push_node, w_push_index};

    mcit_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_queue_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_rdata)
    );

    assign w_cmd_flags = t_cmd_flags'(w_q_rdata[QW-1 -: FLAG_BITS]);
    assign w_cmd_node  = w_q_rdata[INDEX_BITS +: NODE_BITS];
    assign w_cmd_index = w_q_rdata[INDEX_BITS-1:0];

    // Back part: update the table, scan for the majority index, commit.
    mcit_back #(
        .MAX_NODES  (MAX_NODES),
        .INDEX_BITS (INDEX_BITS),
        .NODE_BITS  (NODE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .o_cmd_pop    (w_q_pop),
        .i_cmd_flags  (w_cmd_flags),
        .i_cmd_node   (w_cmd_node),
        .i_cmd_index  (w_cmd_index),
        .i_node_count (r_node_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

[hw/rtl/mcit_checker.sv]
`timescale 1ns / 1ps

module mcit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  mcit_pkg::t_out_word  o_out_data
);
    import mcit_pkg::*;

    // Commit index of the last delivered word; zero after reset.
    logic [31:0] r_last_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_after <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_last_after <= o_out_data.commit_after;
        end
    end

    // A result stays offered until it is taken.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // Results chain: each word starts where the previous one ended.
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |-> (o_out_data.commit_before == r_last_after))
        else $error("commit_before does not follow the previous commit_after");

    // Without an advance the commit index is unchanged.
    a_no_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.advanced) |->
            (o_out_data.commit_after == o_out_data.commit_before))
        else $error("commit index moved without the advanced flag");

endmodule

bind majority_commit_index_tracker mcit_checker u_mcit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/sv/mcit_commit_checker.sv]
`timescale 1ns / 1ps

// Watches both word channels and the configuration port of the commit index
// tracker. It keeps its own copy of the commit state and compares every result
// word against the oldest predicted one.
module mcit_commit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mcit_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mcit_pkg::t_out_word i_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_advances
);

    import mcit_pkg::*;

    localparam int TABLE_NODES = MAX_NODES_DEF;

    logic [31:0] match_idx [TABLE_NODES];
    logic [31:0] commit_idx;
    logic [31:0] term_first;
    logic [31:0] log_len;
    logic [3:0]  nodes_cfg;
    logic [2:0]  leader_cfg;
    t_out_word   commit_queue [$];
    int          bad_count;
    int          seen_count;
    int          moved_count;

    // Applies one input word to the shadow state and returns the result word
    // that the block should produce for it.
    function automatic t_out_word next_commit(input t_in_word w);
        t_out_word   r;
        int          n;
        int          majority;
        int          reach;
        logic        found;
        logic [31:0] best;
        r.commit_before = commit_idx;
        if (w.mode == MODE_START) begin
            log_len    = w.log_index;
            term_first = (w.log_index == '1) ? '1 : w.log_index + 32'd1;
            for (int i = 0; i < TABLE_NODES; i++) match_idx[i] = '0;
        end else begin
            match_idx[w.node] = w.log_index;
            if (w.node == leader_cfg) log_len = w.log_index;
        end
        n        = (nodes_cfg > TABLE_NODES) ? TABLE_NODES : int'(nodes_cfg);
        majority = n / 2 + 1;
        found    = 1'b0;
        best     = '0;
        // A candidate is committable when at least a majority has reached it.
        for (int i = 0; i < n; i++) begin
            reach = 0;
            for (int j = 0; j < n; j++) if (match_idx[j] >= match_idx[i]) reach++;
            if (reach >= majority && (!found || match_idx[i] > best)) begin
                best  = match_idx[i];
                found = 1'b1;
            end
        end
        if (found) begin
            if (best > log_len) best = log_len;
            if (best >= term_first && best > commit_idx) commit_idx = best;
        end
        r.commit_after = commit_idx;
        r.advanced     = (commit_idx > r.commit_before);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_NODES; i++) match_idx[i] = '0;
            commit_idx  = '0;
            term_first  = '0;
            log_len     = '0;
            nodes_cfg   = NODE_COUNT_RST;
            leader_cfg  = SELF_ID_RST;
            commit_queue.delete();
            bad_count   = 0;
            seen_count  = 0;
            moved_count = 0;
        end else begin
            // The result leaving at this edge always belongs to an older word,
            // so it is matched before a word accepted at the same edge is added.
            if (i_out_valid && !i_out_stall) begin
                seen_count++;
                if (i_out_data.advanced) moved_count++;
                if (commit_queue.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected result word before=%0d after=%0d adv=%0d",
                                 $realtime, i_out_data.commit_before,
                                 i_out_data.commit_after, i_out_data.advanced);
                end else begin
                    want = commit_queue.pop_front();
                    if (i_out_data.commit_before !== want.commit_before ||
                        i_out_data.commit_after !== want.commit_after ||
                        i_out_data.advanced !== want.advanced) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: mismatch: got before=%0d after=%0d adv=%0d, %s%0d %0d %0d",
                                     $realtime, i_out_data.commit_before,
                                     i_out_data.commit_after, i_out_data.advanced,
                                     "wanted ", want.commit_before, want.commit_after,
                                     want.advanced);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_NODE_COUNT: nodes_cfg = i_pwdata[3:0];
                    REG_SELF_ID:    leader_cfg = i_pwdata[2:0];
                    default:        ;
                endcase
            end
            if (i_in_valid && !i_in_stall) commit_queue.push_back(next_commit(i_in_data));
        end
        o_mismatches <= bad_count;
        o_pending    <= commit_queue.size();
        o_results    <= seen_count;
        o_advances   <= moved_count;
    end

endmodule

[tb/sv/majority_commit_index_tracker_tb.sv]
`timescale 1ns / 1ps

// Top of the testbench for the commit index tracker. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// result word and counts the failures.
module majority_commit_index_tracker_tb;

    import mcit_pkg::*;

    // The long receiver hold-off, in cycles; long enough to fill the command
    // queue and the output register many times over.
    localparam int HOLD_CYCLES   = 300;
    // Cycles to wait after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 75;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results;
    int advances;

    // Stimulus controls, set by the main sequence and read by the driver
    // and receiver processes.
    logic        tx_gaps_on;
    logic        rx_gaps_on;
    logic        hold_req;
    logic [3:0]  nodes_now;
    logic [2:0]  leader_now;
    logic [31:0] next_len;
    int          words_sent;
    int          settings_seen;

    majority_commit_index_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mcit_commit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_advances   (advances)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run must end well within this time even with every stall at its
    // longest; a hang anywhere ends here.
    initial begin
        #3_000_000;
        $display("majority_commit_index_tracker_tb failed");
        $finish;
    end

    // Receiver side. A requested hold-off keeps stall high for the whole
    // hold-off, otherwise stall comes in random bursts while enabled. Every
    // path ends by driving stall low.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one word and returns once it is taken and any random sender gap
    // after it is over. Valid stays high into the next word unless such a gap
    // follows, so a word to stay valid is never lowered and raised in one step.
    task automatic push_word(input logic mode, input logic [2:0] node, input logic [31:0] idx);
        t_in_word w;
        w.mode      = mode;
        w.node      = node;
        w.log_index = idx;
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Stops offering words and waits until every predicted result has come
    // back, then lets the back part settle.
    task automatic wait_drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes node_count and then self_id, back to back, once the block is idle.
    // Each write is a setup phase followed by an access phase.
    task automatic set_cluster(input logic [3:0] nodes, input logic [2:0] leader);
        int reg_sel;
        wait_drain();
        for (reg_sel = 0; reg_sel < 2; reg_sel++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (reg_sel == 0) ? {REG_NODE_COUNT, 2'b00} : {REG_SELF_ID, 2'b00};
            pwdata  <= (reg_sel == 0) ? {28'd0, nodes} : {29'd0, leader};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        nodes_now  = nodes;
        leader_now = leader;
        settings_seen++;
    endtask

    // One leadership term: a start word followed by match reports. The leader
    // itself mostly grows the log, followers report indices around the log
    // length of this term, and a few reports are stray values or come from
    // nodes outside the cluster. Now and then a term opens below the current
    // commit index, which must never make it move back.
    task automatic run_term(input int updates);
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] v;
        logic [31:0] span;
        logic [2:0]  who;
        int          pick;
        int          cluster;
        if ($urandom_range(0, 19) == 0) base = next_len >> 1;
        else base = next_len + $urandom_range(0, 3);
        len = base;
        push_word(MODE_START, 3'($urandom_range(0, 7)), base);
        cluster = (nodes_now == 0) ? 1 : ((nodes_now > 8) ? 8 : int'(nodes_now));
        repeat (updates) begin
            pick = $urandom_range(0, 99);
            who  = (pick < 85) ? 3'($urandom_range(0, cluster - 1)) : 3'($urandom_range(0, 7));
            if (pick < 30) who = leader_now;
            span = len - base;
            if (who == leader_now) begin
                // A short log now and then, otherwise the log grows.
                v   = (pick < 3 && span > 0) ? len - 32'd1 : len + $urandom_range(0, 4);
                len = v;
            end else if (pick >= 92) begin
                v = $urandom;
            end else begin
                v = base + $urandom_range(0, span + 1);
            end
            push_word(MODE_UPDATE, who, v);
        end
        if (len >= next_len) next_len = len + 32'd1;
    endtask

    task automatic run_random(input int words);
        int goal;
        goal = words_sent + words;
        while (words_sent < goal) run_term($urandom_range(3, 24));
    endtask

    initial begin
        // Every input is known from time zero; reset is asserted from the start.
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        tx_gaps_on    = 1'b0;
        rx_gaps_on    = 1'b0;
        hold_req      = 1'b0;
        nodes_now     = NODE_COUNT_RST;
        leader_now    = SELF_ID_RST;
        next_len      = 32'd100;
        words_sent    = 0;
        settings_seen = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words with the reset setting of three nodes, leader zero.
        // The leader reports before any term has been opened, then one
        // follower catches up and the first commit happens.
        push_word(MODE_UPDATE, 3'd0, 32'd10);
        push_word(MODE_UPDATE, 3'd1, 32'd10);
        // A new term; the node field of a start word is ignored.
        push_word(MODE_START, 3'd7, 32'd20);
        push_word(MODE_UPDATE, 3'd0, 32'd25);
        push_word(MODE_UPDATE, 3'd2, 32'd23);
        // A node beyond node_count is stored but must not count.
        push_word(MODE_UPDATE, 3'd7, 32'd100);
        // The log shrinks below the commit index, which must hold.
        push_word(MODE_UPDATE, 3'd0, 32'd22);
        push_word(MODE_UPDATE, 3'd1, 32'd30);
        // An empty log, then a term start at the top of the index range,
        // where the term start saturates instead of wrapping to zero.
        push_word(MODE_START, 3'd0, 32'd0);
        push_word(MODE_UPDATE, 3'd0, 32'd0);
        push_word(MODE_UPDATE, 3'd1, 32'd0);
        push_word(MODE_START, 3'd5, 32'hFFFF_FFFF);
        push_word(MODE_UPDATE, 3'd0, 32'hFFFF_FFFF);
        push_word(MODE_UPDATE, 3'd2, 32'hFFFF_FFFE);
        // A follower reports an index far ahead of the log length.
        push_word(MODE_START, 3'd2, 32'd40);
        push_word(MODE_UPDATE, 3'd1, 32'hFFFF_FFFF);
        push_word(MODE_UPDATE, 3'd0, 32'd45);
        // The remaining table entries, all outside the cluster.
        push_word(MODE_UPDATE, 3'd3, 32'h5555_5555);
        push_word(MODE_UPDATE, 3'd4, 32'hAAAA_AAAA);
        push_word(MODE_UPDATE, 3'd5, 32'd46);
        push_word(MODE_UPDATE, 3'd6, 32'd47);

        // The receiver holds off for a long stretch while the sender keeps
        // offering words, so the block fills and stalls its input.
        hold_req = 1'b1;
        run_term(20);

        // Random terms under a series of cluster settings, including one node,
        // eight nodes, none at all, counts above the table size and a leader
        // outside the cluster. Each change waits until the block has drained.
        set_cluster(4'd1, 3'd0);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_random(PHASE_WORDS);
        set_cluster(4'd8, 3'd7);
        run_random(PHASE_WORDS);
        set_cluster(4'd5, 3'd2);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(PHASE_WORDS);
        set_cluster(4'd0, 3'd3);
        tx_gaps_on = 1'b1;
        run_random(PHASE_WORDS / 2);
        // Jump the log far up so the upper index bits are used from here on.
        next_len = next_len + 32'h7FFF_0000;
        set_cluster(4'd15, 3'd4);
        rx_gaps_on = 1'b1;
        run_random(PHASE_WORDS);
        set_cluster(4'd9, 3'd1);
        tx_gaps_on = 1'b0;
        run_random(PHASE_WORDS);
        set_cluster(4'd2, 3'd5);
        tx_gaps_on = 1'b1;
        run_random(PHASE_WORDS);
        set_cluster(4'd4, 3'd7);
        run_random(PHASE_WORDS);
        set_cluster(4'd7, 3'd6);
        run_random(PHASE_WORDS);

        // Last part without any idling on either side, ending with a commit
        // at the very top of the index range. Nothing can advance after that.
        set_cluster(NODE_COUNT_RST, SELF_ID_RST);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(PHASE_WORDS);
        push_word(MODE_START, 3'd0, 32'hFFFF_FFFE);
        push_word(MODE_UPDATE, 3'd0, 32'hFFFF_FFFF);
        push_word(MODE_UPDATE, 3'd1, 32'hFFFF_FFFF);
        push_word(MODE_UPDATE, 3'd2, 32'd0);

        wait_drain();
        $display("Sent %0d words under %0d cluster settings; %0d result words checked,",
                 words_sent, settings_seen, results);
        $display("%0d of them moved the commit index forward.", advances);
        if (mismatches == 0 && pending == 0) begin
            $display("majority_commit_index_tracker_tb passed");
        end else begin
            $display("majority_commit_index_tracker_tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mcit_pkg.sv
hw/rtl/mcit_front.sv
hw/rtl/mcit_queue.sv
hw/rtl/mcit_back.sv
hw/rtl/majority_commit_index_tracker.sv
hw/rtl/mcit_checker.sv
tb/sv/mcit_commit_checker.sv
tb/sv/majority_commit_index_tracker_tb.sv
